[rtl/triangle_tangent_bitangent_core_macros.svh]
// assertion macros shared by the tangent basis core
// no dependencies; included by the top level only
`ifndef TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttb assertion failed");

// next-cycle implication, checked out of reset
`define TTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttb assertion failed");

`endif

[rtl/ttb_pkg.sv]
// widths, types and control structs of the tangent basis core
// no dependencies
package ttb_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int PROD_W    = 2 * DELTA_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int SNUM_W    = NUM_W + FRAC_W;
  localparam int REM_W     = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(SNUM_W);
  localparam int RES_N     = 6;
  localparam int TERM_W    = 3;

  // term codes: determinant, then three tangent and three bitangent numerators
  localparam logic [TERM_W-1:0] TERM_DET  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_TX   = 3'd1;
  localparam logic [TERM_W-1:0] TERM_TY   = 3'd2;
  localparam logic [TERM_W-1:0] TERM_TZ   = 3'd3;
  localparam logic [TERM_W-1:0] TERM_BX   = 3'd4;
  localparam logic [TERM_W-1:0] TERM_BY   = 3'd5;
  localparam logic [TERM_W-1:0] TERM_BZ   = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    logic              wr_slot0;
    logic              wr_slot1;
    logic              wr_cur;
    logic              ld_delta;
    logic              mul_en;
    logic              mul_sel;
    logic              acc_ld;
    logic              acc_sub;
    logic              det_ld;
    logic              div_start;
    logic              res_wr;
    logic              out_load;
    logic [TERM_W-1:0] term;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } stat_t;

endpackage

[rtl/ttb_div.sv]
// restoring divider: saturated (num * 2^16) / den, one quotient bit a cycle
// depends on ttb_pkg
module ttb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ttb_pkg::NUM_W-1:0] num,
  input  logic signed [ttb_pkg::NUM_W-1:0] den,
  output logic                          done,
  output ttb_pkg::coord_t               quot
);
  import ttb_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(SNUM_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SNUM_W-1:0]    n_r, n_nxt;
  logic [SNUM_W-1:0]    q_r, q_nxt;
  logic [NUM_W-1:0]     d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic [NUM_W-1:0]     num_mag, den_mag;
  logic [REM_W-1:0]     trial;
  logic                 ge;
  logic [SNUM_W-1:0]    limit, q_sat;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);

  // one shift-and-subtract step
  assign trial = {rem_r[REM_W-2:0], n_r[SNUM_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      n_nxt    = {num_mag, {FRAC_W{1'b0}}};
      q_nxt    = '0;
      d_nxt    = den_mag;
      neg_nxt  = num[NUM_W-1] ^ den[NUM_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, d_r} : trial;
      n_nxt   = {n_r[SNUM_W-2:0], 1'b0};
      q_nxt   = {q_r[SNUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  // saturate magnitude, then apply sign
  assign limit = neg_r ? (SNUM_W'(1) << (COORD_W - 1))
                       : ((SNUM_W'(1) << (COORD_W - 1)) - SNUM_W'(1));
  assign q_sat = (q_r > limit) ? limit : q_r;
  assign quot  = neg_r ? coord_t'(-q_sat[COORD_W-1:0]) : coord_t'(q_sat[COORD_W-1:0]);
  assign done  = done_r;

endmodule

[rtl/ttb_dp.sv]
// datapath: held vertices, deltas, shared multiplier, accumulator, divider
// depends on ttb_pkg and ttb_div
module ttb_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ttb_pkg::cmd_t   cmd,
  output ttb_pkg::stat_t  stat,
  input  ttb_pkg::coord_t pos_x,
  input  ttb_pkg::coord_t pos_y,
  input  ttb_pkg::coord_t pos_z,
  input  ttb_pkg::coord_t tex_u,
  input  ttb_pkg::coord_t tex_v,
  output ttb_pkg::coord_t res [ttb_pkg::RES_N]
);
  import ttb_pkg::*;

  coord_t p0_r [3];
  coord_t p1_r [3];
  coord_t p2_r [3];
  coord_t t0_r [2];
  coord_t t1_r [2];
  coord_t t2_r [2];
  delta_t dp1_r [3];
  delta_t dp2_r [3];
  delta_t du1_r, dv1_r, du2_r, dv2_r;
  delta_t op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NUM_W-1:0]  acc_r, det_r, prod_ext;
  coord_t res_r [RES_N];
  logic   div_done;
  coord_t quot;
  logic [TERM_W-1:0] res_idx;

  // vertex capture
  always_ff @(posedge clk) begin
    if (cmd.wr_slot0) begin
      p0_r[0] <= pos_x; p0_r[1] <= pos_y; p0_r[2] <= pos_z;
      t0_r[0] <= tex_u; t0_r[1] <= tex_v;
    end
    if (cmd.wr_slot1) begin
      p1_r[0] <= pos_x; p1_r[1] <= pos_y; p1_r[2] <= pos_z;
      t1_r[0] <= tex_u; t1_r[1] <= tex_v;
    end
    if (cmd.wr_cur) begin
      p2_r[0] <= pos_x; p2_r[1] <= pos_y; p2_r[2] <= pos_z;
      t2_r[0] <= tex_u; t2_r[1] <= tex_v;
    end
  end

  // edge and texture deltas
  always_ff @(posedge clk) begin
    if (cmd.ld_delta) begin
      for (int k = 0; k < 3; k++) begin
        dp1_r[k] <= delta_t'(p1_r[k]) - delta_t'(p0_r[k]);
        dp2_r[k] <= delta_t'(p2_r[k]) - delta_t'(p0_r[k]);
      end
      du1_r <= delta_t'(t1_r[0]) - delta_t'(t0_r[0]);
      dv1_r <= delta_t'(t1_r[1]) - delta_t'(t0_r[1]);
      du2_r <= delta_t'(t2_r[0]) - delta_t'(t0_r[0]);
      dv2_r <= delta_t'(t2_r[1]) - delta_t'(t0_r[1]);
    end
  end

  // operand pair for the current term
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.term)
      TERM_DET: begin
        op_a = cmd.mul_sel ? dv1_r : du1_r;
        op_b = cmd.mul_sel ? du2_r : dv2_r;
      end
      TERM_TX: begin
        op_a = cmd.mul_sel ? dp2_r[0] : dp1_r[0];
        op_b = cmd.mul_sel ? dv1_r : dv2_r;
      end
      TERM_TY: begin
        op_a = cmd.mul_sel ? dp2_r[1] : dp1_r[1];
        op_b = cmd.mul_sel ? dv1_r : dv2_r;
      end
      TERM_TZ: begin
        op_a = cmd.mul_sel ? dp2_r[2] : dp1_r[2];
        op_b = cmd.mul_sel ? dv1_r : dv2_r;
      end
      TERM_BX: begin
        op_a = cmd.mul_sel ? dp1_r[0] : dp2_r[0];
        op_b = cmd.mul_sel ? du2_r : du1_r;
      end
      TERM_BY: begin
        op_a = cmd.mul_sel ? dp1_r[1] : dp2_r[1];
        op_b = cmd.mul_sel ? du2_r : du1_r;
      end
      TERM_BZ: begin
        op_a = cmd.mul_sel ? dp1_r[2] : dp2_r[2];
        op_b = cmd.mul_sel ? du2_r : du1_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier and difference accumulator
  assign prod_ext = NUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= op_a * op_b;
    if (cmd.acc_ld) acc_r <= prod_ext;
    else if (cmd.acc_sub) acc_r <= acc_r - prod_ext;
    if (cmd.det_ld) det_r <= acc_r - prod_ext;
  end

  ttb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_r),
    .den   (det_r),
    .done  (div_done),
    .quot  (quot)
  );

  // result slots, tangent then bitangent
  assign res_idx = cmd.term - TERM_TX;

  always_ff @(posedge clk) begin
    if (cmd.res_wr) res_r[res_idx] <= quot;
  end

  assign res           = res_r;
  assign stat.det_zero = (det_r == '0);
  assign stat.div_done = div_done;

endmodule

[rtl/ttb_ctrl.sv]
// controller: vertex phase and the per-triangle compute sequence
// depends on ttb_pkg
module ttb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mesh_start,
  output logic           in_stall,
  input  logic           out_free,
  input  ttb_pkg::stat_t stat,
  output ttb_pkg::cmd_t  cmd
);
  import ttb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] PH_V0 = 2'd0;
  localparam logic [1:0] PH_V1 = 2'd1;
  localparam logic [1:0] PH_V2 = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [1:0]        eff_phase;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // restart or unused phase code starts a triangle
  assign eff_phase = (in_mesh_start || phase_r == 2'd3) ? PH_V0 : phase_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    term_nxt  = term_r;
    cmd       = '0;
    cmd.term  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (eff_phase)
            PH_V0: begin
              cmd.wr_slot0 = 1'b1;
              phase_nxt    = PH_V1;
            end
            PH_V1: begin
              cmd.wr_slot1 = 1'b1;
              phase_nxt    = PH_V2;
            end
            default: begin
              cmd.wr_cur = 1'b1;
              phase_nxt  = PH_V0;
              state_nxt  = S_DELTA;
            end
          endcase
        end
      end
      S_DELTA: begin
        cmd.ld_delta = 1'b1;
        term_nxt     = TERM_DET;
        state_nxt    = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
        cmd.acc_ld  = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        if (term_r == TERM_DET) begin
          cmd.det_ld = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          cmd.acc_sub = 1'b1;
          state_nxt   = S_DIVGO;
        end
      end
      S_CHK: begin
        if (stat.det_zero) begin
          state_nxt = S_OUT;
        end else begin
          term_nxt  = TERM_TX;
          state_nxt = S_MUL0;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.res_wr = 1'b1;
          if (term_r == TERM_BZ) begin
            state_nxt = S_OUT;
          end else begin
            term_nxt  = term_r + 1'b1;
            state_nxt = S_MUL0;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_V0;
      term_r  <= TERM_DET;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

[rtl/triangle_tangent_bitangent_core.sv]
// top level of the per-triangle tangent basis core
// depends on ttb_pkg, ttb_ctrl, ttb_dp and the macros header
//
//   channel  direction  word
//   in_      input      one vertex: position, texture coordinate, mesh start
//   out_     output     one triangle: tangent, bitangent, degenerate flag
//
// first and second vertex of a triangle: taken without holding off the input
// third vertex: input held off while the 83-step restoring divider, shared by
//   the six components, works through them; degenerate triangles skip the divider
// a finished word waits in the output register while a new vertex is taken
// reset is synchronous, active low, and restarts triangle grouping
`include "triangle_tangent_bitangent_core_macros.svh"

module triangle_tangent_bitangent_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ttb_pkg::coord_t in_pos_x,
  input  ttb_pkg::coord_t in_pos_y,
  input  ttb_pkg::coord_t in_pos_z,
  input  ttb_pkg::coord_t in_tex_u,
  input  ttb_pkg::coord_t in_tex_v,
  input  logic            in_mesh_start,
  output logic            out_valid,
  input  logic            out_stall,
  output ttb_pkg::coord_t out_tangent_x,
  output ttb_pkg::coord_t out_tangent_y,
  output ttb_pkg::coord_t out_tangent_z,
  output ttb_pkg::coord_t out_bitangent_x,
  output ttb_pkg::coord_t out_bitangent_y,
  output ttb_pkg::coord_t out_bitangent_z,
  output logic            out_degenerate
);
  import ttb_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  coord_t res [RES_N];
  logic   out_free;
  logic   out_valid_r, out_valid_nxt;
  coord_t out_r [RES_N];
  logic   deg_r;

  assign out_free = !out_valid_r || !out_stall;

  ttb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_mesh_start (in_mesh_start),
    .in_stall      (in_stall),
    .out_free      (out_free),
    .stat          (stat),
    .cmd           (cmd)
  );

  ttb_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .tex_u (in_tex_u),
    .tex_v (in_tex_v),
    .res   (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      deg_r <= stat.det_zero;
      for (int k = 0; k < RES_N; k++) out_r[k] <= stat.det_zero ? '0 : res[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_r[0];
  assign out_tangent_y   = out_r[1];
  assign out_tangent_z   = out_r[2];
  assign out_bitangent_x = out_r[3];
  assign out_bitangent_y = out_r[4];
  assign out_bitangent_z = out_r[5];
  assign out_degenerate  = deg_r;

  // degenerate words carry zero vectors
  `TTB_ASSERT_NOW(a_deg_zero, clk, rst_n, out_valid && out_degenerate, out_tangent_x == '0 && out_bitangent_z == '0)
  // a word is loaded only into a free output register
  `TTB_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall)
  // divider completes only while the input side is held off
  `TTB_ASSERT_NOW(a_div_busy, clk, rst_n, stat.div_done, in_stall)
  // a load always presents a word on the next cycle
  `TTB_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid)

endmodule

[tb/tb_triangle_tangent_bitangent_core.sv]
// self-checking bench for the per-triangle tangent basis core: vertex words in,
// one tangent/bitangent word per triangle out, checked against a local predictor
// depends on ttb_pkg and triangle_tangent_bitangent_core
module tb_triangle_tangent_bitangent_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ttb_pkg::*;

  typedef struct {
    coord_t px, py, pz, tu, tv;
    logic   mesh_start;
    logic   wait_drain;
  } vertex_t;

  typedef struct {
    coord_t tx, ty, tz, bx, by, bz;
    logic   degenerate;
  } basis_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 600;
  localparam int HOLD_CYCLES = 3000;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_pos_x = '0, in_pos_y = '0, in_pos_z = '0, in_tex_u = '0, in_tex_v = '0;
  logic   in_mesh_start = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_tangent_x, out_tangent_y, out_tangent_z;
  coord_t out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic   out_degenerate;

  vertex_t vertex_q[$];
  basis_t  basis_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      sent = 0;
  int      results = 0;
  logic    in_taken = 1'b0;
  int      hold_left = 0;
  logic    hold_done = 1'b0;

  // predictor state: two held vertices and the position within the triangle
  coord_t  held_pos[6];
  coord_t  held_tex[4];
  int      phase = 0;

  triangle_tangent_bitangent_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // num * 2^16 / den, toward zero, saturated to the coordinate range
  function automatic coord_t scaled_quot(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FRAC_W) / den;
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic basis_t tangent_basis(coord_t p[9], coord_t t[6]);
    logic signed [127:0] dp1[3], dp2[3], du1, dv1, du2, dv2, det;
    basis_t b;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = 128'(p[3+k]) - 128'(p[k]);
      dp2[k] = 128'(p[6+k]) - 128'(p[k]);
    end
    du1 = 128'(t[2]) - 128'(t[0]);
    dv1 = 128'(t[3]) - 128'(t[1]);
    du2 = 128'(t[4]) - 128'(t[0]);
    dv2 = 128'(t[5]) - 128'(t[1]);
    det = du1 * dv2 - dv1 * du2;
    b = '{default: '0};
    if (det == 0) begin
      b.degenerate = 1'b1;
      return b;
    end
    b.tx = scaled_quot(dp1[0] * dv2 - dp2[0] * dv1, det);
    b.ty = scaled_quot(dp1[1] * dv2 - dp2[1] * dv1, det);
    b.tz = scaled_quot(dp1[2] * dv2 - dp2[2] * dv1, det);
    b.bx = scaled_quot(dp2[0] * du1 - dp1[0] * du2, det);
    b.by = scaled_quot(dp2[1] * du1 - dp1[1] * du2, det);
    b.bz = scaled_quot(dp2[2] * du1 - dp1[2] * du2, det);
    return b;
  endfunction

  // mix of small, full-range and extreme coordinates
  function automatic coord_t pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return coord_t'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
    if (sel < 90) return coord_t'($urandom);
    if (sel < 95) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  function automatic vertex_t make_vertex(coord_t x, coord_t y, coord_t z, coord_t u,
                                          coord_t v, logic ms);
    vertex_t w;
    w = '{px: x, py: y, pz: z, tu: u, tv: v, mesh_start: ms, wait_drain: 1'b0};
    return w;
  endfunction

  // append a vertex word to the pending stimulus
  task automatic add_vertex(vertex_t w);
    vertex_q.insert(vertex_q.size(), w);
  endtask

  task automatic check_field(string name, coord_t exp_v, coord_t act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_triangle_tangent_bitangent_core: done, errors");
      $finish;
    end
  end

  // input monitor: feeds the predictor with every accepted vertex word
  always @(posedge clk) begin
    coord_t p[9];
    coord_t t[6];
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      sent++;
      if (in_mesh_start) phase = 0;
      if (phase < 2) begin
        held_pos[phase*3]   = in_pos_x;
        held_pos[phase*3+1] = in_pos_y;
        held_pos[phase*3+2] = in_pos_z;
        held_tex[phase*2]   = in_tex_u;
        held_tex[phase*2+1] = in_tex_v;
        phase++;
      end else begin
        for (int k = 0; k < 6; k++) p[k] = held_pos[k];
        p[6] = in_pos_x; p[7] = in_pos_y; p[8] = in_pos_z;
        for (int k = 0; k < 4; k++) t[k] = held_tex[k];
        t[4] = in_tex_u; t[5] = in_tex_v;
        basis_q.insert(basis_q.size(), tangent_basis(p, t));
        phase = 0;
      end
    end
  end

  // output monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (basis_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h %h %h %h %h %h %b", $time,
                 out_tangent_x, out_tangent_y, out_tangent_z, out_bitangent_x,
                 out_bitangent_y, out_bitangent_z, out_degenerate);
      end else begin
        e = basis_q.pop_front();
        check_field("tangent_x", e.tx, out_tangent_x);
        check_field("tangent_y", e.ty, out_tangent_y);
        check_field("tangent_z", e.tz, out_tangent_z);
        check_field("bitangent_x", e.bx, out_bitangent_x);
        check_field("bitangent_y", e.by, out_bitangent_y);
        check_field("bitangent_z", e.bz, out_bitangent_z);
        if (e.degenerate !== out_degenerate) begin
          errors++;
          $display("%0t: degenerate mismatch, expected %b, got %b", $time, e.degenerate,
                   out_degenerate);
        end
      end
    end
  end

  // driver: holds a word until taken, idles at random except in a quiet stretch
  always @(negedge clk) begin
    vertex_t w;
    if (rst_n && (!in_valid || in_taken)) begin
      if (vertex_q.size() != 0 && !(vertex_q[0].wait_drain && basis_q.size() != 0) &&
          ((sent >= 300 && sent < 420) || $urandom_range(99) >= 23)) begin
        w = vertex_q.pop_front();
        in_pos_x      <= w.px;
        in_pos_y      <= w.py;
        in_pos_z      <= w.pz;
        in_tex_u      <= w.tu;
        in_tex_v      <= w.tv;
        in_mesh_start <= w.mesh_start;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off, no stalls for a stretch
  always @(negedge clk) begin
    if (!hold_done && results == 30) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (results >= 110 && results < 150) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 23);
    end
  end

  // stimulus and end of run
  initial begin
    vertex_t w;
    // an extreme value in each field
    add_vertex(make_vertex(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 1'b0));
    add_vertex(make_vertex(32'sh80000000, 32'sh7fffffff, -1, 32'sh7fffffff, 0, 1'b0));
    add_vertex(make_vertex(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0));
    // ordinary unit triangle
    add_vertex(make_vertex(0, 0, 0, 0, 0, 1'b1));
    add_vertex(make_vertex(32'h10000, 0, 0, 32'h10000, 0, 1'b0));
    add_vertex(make_vertex(0, 32'h10000, 0, 0, 32'h10000, 1'b0));
    // zero determinant: identical texture coordinates
    add_vertex(make_vertex(1, 2, 3, 32'h5000, 32'h5000, 1'b1));
    add_vertex(make_vertex(4, 5, 6, 32'h5000, 32'h5000, 1'b0));
    add_vertex(make_vertex(7, 8, 9, 32'h5000, 32'h5000, 1'b0));
    // saturation: tiny determinant, huge edges
    add_vertex(make_vertex(32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1'b1));
    add_vertex(make_vertex(32'sh7fffffff, 32'sh80000000, 5, 1, 0, 1'b0));
    add_vertex(make_vertex(0, 0, 32'sh80000000, 0, 1, 1'b0));
    // mesh restart on the second and on the third vertex
    add_vertex(make_vertex(9, 9, 9, 9, 9, 1'b1));
    add_vertex(make_vertex(1, 1, 1, 32'h20000, 0, 1'b1));
    add_vertex(make_vertex(3, 3, 3, 0, 32'h20000, 1'b0));
    add_vertex(make_vertex(5, 5, 5, 5, 5, 1'b1));
    add_vertex(make_vertex(32'h30000, 0, 0, 32'h8000, 0, 1'b0));
    add_vertex(make_vertex(0, 32'h30000, 32'h1000, 32'h100, 32'h8000, 1'b0));
    // random part: mostly clean triangles, some restarts and zero determinants
    while (vertex_q.size() < 600) begin
      for (int k = 0; k < 3; k++) begin
        w = make_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), k == 0 ? ($urandom_range(99) < 80) : 1'b0);
        if (k != 0 && $urandom_range(99) < 5) w.mesh_start = 1'b1;
        if (k != 0 && $urandom_range(99) < 6) begin
          w.tu = vertex_q[vertex_q.size()-1].tu;
          w.tv = vertex_q[vertex_q.size()-1].tv;
        end
        if (vertex_q.size() == 200) w.wait_drain = 1'b1;
        add_vertex(w);
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (vertex_q.size() == 0 && !in_valid);
    wait (basis_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (basis_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, basis_q.size());
    end
    if (errors == 0) begin
      $display("tb_triangle_tangent_bitangent_core: done, clean");
    end else begin
      $display("tb_triangle_tangent_bitangent_core: done, errors");
    end
    $finish;
  end

endmodule
